// File: hw/rtl/sbc_pkg.sv
`default_nettype none
package sbc_pkg;

  typedef enum logic [2:0] {
    OP_IDLE    = 3'd0,
    OP_START   = 3'd1,
    OP_RESTART = 3'd2,
    OP_STOP    = 3'd3,
    OP_WRITE   = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  localparam int unsigned PhaseW    = 5;
  localparam logic [PhaseW-1:0] ByteHalves = 5'd18;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    op_t               op;
    logic [7:0]        shift_byte;
    logic [3:0]        bit_index;
    logic              clock_out;
    logic              data_enable;
    logic              data_out;
    logic              ack_hold;
    logic [7:0]        last_read;
    logic              ack_tx;
  } sbc_state_t;

  typedef struct packed {
    logic       ack_seen;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_level;
    logic       sda_enable;
    logic       scl_level;
  } sbc_result_t;

  // Number of half-cycles in each command sequence.
  function automatic logic [PhaseW-1:0] seq_length(op_t op);
    logic [PhaseW-1:0] len;
    unique case (op)
      OP_START:           len = 5'd3;
      OP_RESTART:         len = 5'd4;
      OP_STOP:            len = 5'd3;
      OP_WRITE, OP_READ:  len = ByteHalves;
      default:            len = '0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/serial_bus_controller_phy_top.sv
`default_nettype none
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_tvalid/s_tready  | tuser: command, tdata: byte, ack, SDA sample
// m_      | out       | m_tvalid/m_tready  | tdata: pins, busy, done, read byte, ack
//
// One item per clock cycle while s_tready is high: each item updates the bus
// state in the cycle it is accepted; its result is registered for the m_ side.
// A two-entry result buffer (output register plus skid register) lets the slave
// side keep accepting while a result waits; s_tready drops only when both hold.
// Reset: SCL high, SDA released, no command in progress, both buffers empty.
module serial_bus_controller_phy_top
  import sbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [2:0]  s_tuser,   // [2:0] action
  input  wire logic [15:0] s_tdata,   // [7:0] data_byte, [8] send_ack, [9] sda_in
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // [0] scl_level, [1] sda_enable, [2] sda_level, [3] busy_res, [4] done_res,
  // [12:5] read_data, [13] ack_seen
  output      logic [15:0] m_tdata
);

  sbc_result_t res_new;
  sbc_result_t out_res;
  sbc_result_t skid_res;
  logic        out_valid;
  logic        skid_valid;
  logic        fire;
  logic        pop;

  assign s_tready = !skid_valid;
  assign fire     = s_tvalid && s_tready;
  assign pop      = out_valid && m_tready;

  sbc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .action    (s_tuser),
    .data_byte (s_tdata[7:0]),
    .send_ack  (s_tdata[8]),
    .sda_in    (s_tdata[9]),
    .res       (res_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= fire;
      end
    end else if (fire) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (fire) begin
        out_res <= res_new;
      end
    end else if (fire) begin
      if (out_valid) begin
        skid_res <= res_new;
      end else begin
        out_res <= res_new;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res};

endmodule
`default_nettype wire

// File: hw/rtl/sbc_core.sv
`default_nettype none
module sbc_core
  import sbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire logic [2:0]  action,
  input  wire logic [7:0]  data_byte,
  input  wire logic        send_ack,
  input  wire logic        sda_in,
  output sbc_result_t      res
);

  sbc_state_t        st;
  sbc_state_t        st_next;
  logic              done;
  logic              enter;
  logic [PhaseW-1:0] ph;
  logic [PhaseW-1:0] p_inc;
  logic [3:0]        bi;
  logic              byte_op;

  assign byte_op = (st.op == OP_WRITE) || (st.op == OP_READ);
  assign p_inc   = st.phase + 5'd1;

  always_comb begin
    st_next = st;
    done    = 1'b0;
    enter   = 1'b0;
    ph      = '0;
    if (st.op == OP_IDLE) begin
      // A tick or an unused code while idle changes nothing.
      if (action >= OP_START && action <= OP_READ) begin
        st_next.op        = op_t'(action);
        st_next.phase     = '0;
        st_next.bit_index = '0;
        if (action == OP_WRITE) begin
          st_next.shift_byte = data_byte;
        end else if (action == OP_READ) begin
          st_next.shift_byte = '0;
          st_next.ack_tx     = send_ack;
        end
        enter = 1'b1;
      end
    end else begin
      // Any command while busy acts as a tick.
      if (byte_op && st.phase[0]) begin
        if (st.op == OP_READ && st.phase < 5'd16) begin
          st_next.shift_byte = {st.shift_byte[6:0], sda_in};
        end
        if (st.op == OP_WRITE && st.phase == 5'd17) begin
          st_next.ack_hold = ~sda_in;
        end
        st_next.clock_out = 1'b0;
      end
      if (p_inc >= seq_length(st.op)) begin
        if (st.op == OP_READ) begin
          st_next.last_read = st_next.shift_byte;
        end
        st_next.op    = OP_IDLE;
        st_next.phase = '0;
        done          = 1'b1;
      end else begin
        st_next.phase = p_inc;
        enter         = 1'b1;
        ph            = p_inc;
      end
    end

    bi = ph[4:1];

    // Pin setup at the start of the next half-cycle.
    if (enter) begin
      case (st_next.op)
        OP_START: begin
          if (ph == 5'd0) begin
            st_next.data_enable = 1'b0;
            st_next.data_out    = 1'b0;
            st_next.clock_out   = 1'b1;
          end else if (ph == 5'd1) begin
            st_next.data_enable = 1'b1;
            st_next.data_out    = 1'b0;
          end else begin
            st_next.clock_out = 1'b0;
          end
        end
        OP_RESTART: begin
          if (ph == 5'd0) begin
            st_next.data_enable = 1'b0;
            st_next.data_out    = 1'b0;
          end else if (ph == 5'd1) begin
            st_next.clock_out = 1'b1;
          end else if (ph == 5'd2) begin
            st_next.data_enable = 1'b1;
            st_next.data_out    = 1'b0;
          end else begin
            st_next.clock_out = 1'b0;
          end
        end
        OP_STOP: begin
          if (ph == 5'd0) begin
            st_next.data_enable = 1'b1;
            st_next.data_out    = 1'b0;
          end else if (ph == 5'd1) begin
            st_next.clock_out = 1'b1;
          end else begin
            st_next.data_enable = 1'b0;
            st_next.data_out    = 1'b0;
          end
        end
        OP_WRITE, OP_READ: begin
          st_next.bit_index = bi;
          if (ph[0]) begin
            st_next.clock_out = 1'b1;
          end else if (!bi[3]) begin
            if (st_next.op == OP_WRITE) begin
              st_next.data_enable = 1'b1;
              st_next.data_out    = st_next.shift_byte[~bi[2:0]];
            end else begin
              st_next.data_enable = 1'b0;
              st_next.data_out    = 1'b0;
            end
          end else begin
            // Acknowledge bit: released on write; on read, driven low only if send_ack set.
            st_next.data_enable = (st_next.op == OP_READ) && st_next.ack_tx;
            st_next.data_out    = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.scl_level  = st_next.clock_out;
    res.sda_enable = st_next.data_enable;
    res.sda_level  = st_next.data_enable & st_next.data_out;
    res.busy_res   = (st_next.op != OP_IDLE);
    res.done_res   = done;
    res.read_data  = st_next.last_read;
    res.ack_seen   = st_next.ack_hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= '0;
      st.op          <= OP_IDLE;
      st.shift_byte  <= '0;
      st.bit_index   <= '0;
      st.clock_out   <= 1'b1;
      st.data_enable <= 1'b0;
      st.data_out    <= 1'b0;
      st.ack_hold    <= 1'b0;
      st.last_read   <= '0;
      st.ack_tx      <= 1'b0;
    end else if (fire) begin
      st <= st_next;
    end
  end

endmodule
`default_nettype wire
